FILE: design/brb_pkg.sv
`timescale 1ns / 1ps
// brb_pkg: types and constants shared by the byte ring buffer modules
// no dependencies

package brb_pkg;

  localparam int CFG_W    = 9;
  localparam int MIN_SIZE = 2;

  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_POP    = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] transfer_count;
    logic [7:0] data_in;
  } req_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] data_out;
    logic       last_of_transfer;
    logic       has_space;
    logic [7:0] fill_level;
    logic [7:0] peak_usage;
  } rsp_t;

  // result fields known at accept time; the popped byte follows from the ram
  typedef struct packed {
    status_t    status;
    logic       last;
    logic       has_space;
    logic [7:0] fill_level;
    logic [7:0] peak_usage;
    logic       pop_data;
  } res_t;

endpackage

FILE: design/byte_ring_buffer_burst.sv
`timescale 1ns / 1ps
// byte_ring_buffer_burst: top level, byte store ram, control and result register
// depends on brb_pkg, brb_ram, brb_ctrl
//
// Byte ring buffer with all-or-nothing append and pop transfers.
// req channel (req_valid, req_stall, req_word): one byte slot per word; the
//   opening word of a transfer gives its kind and length, query is one word.
// rsp channel (rsp_valid, rsp_stall, rsp_word): exactly one result word per
//   request word, in order.
// cfg channel (cfg_valid, cfg_ready, cfg_data): buffer size, always ready;
//   a write empties the buffer and cancels an open transfer, peak is kept.
// Result: registered; it appears in the cycle after its request word is accepted.
// Throughput: one word per cycle while no stall holds; the byte store is one ram with one write
//   and one registered read port, and the pop byte comes out of its read
//   register straight into the result.
// Stall: while rsp_stall holds a waiting result, req_stall is raised and the
//   result, including the popped byte, holds.
// Reset: buffer empty, no transfer open, peak zero, size min(256, DEPTH);
//   no clearing pass, the ram is not initialised.

module byte_ring_buffer_burst import brb_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_t             req_word,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_t             rsp_word,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int PW = $clog2(DEPTH);

  logic          acc;
  res_t          res, res_q;
  logic          mem_we, mem_re;
  logic [PW-1:0] mem_addr;
  logic [7:0]    mem_wdata, mem_rdata;

  assign cfg_ready = 1'b1;
  assign req_stall = rsp_valid && rsp_stall;
  assign acc       = req_valid && !req_stall;

  brb_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .acc       (acc),
    .req       (req_word),
    .res       (res),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata)
  );

  brb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_addr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_addr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (acc) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_q <= res;
    end
  end

  always_comb begin
    rsp_word.status           = res_q.status;
    rsp_word.data_out         = res_q.pop_data ? mem_rdata : 8'd0;
    rsp_word.last_of_transfer = res_q.last;
    rsp_word.has_space        = res_q.has_space;
    rsp_word.fill_level       = res_q.fill_level;
    rsp_word.peak_usage       = res_q.peak_usage;
  end

  a_word_out: assert property (@(posedge clk) disable iff (rst) acc |=> rsp_valid)
    else $error("accepted word gave no result");

  a_stall_src: assert property (@(posedge clk) disable iff (rst) req_stall |-> rsp_valid)
    else $error("input stalled with no result waiting");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_word))
    else $error("stalled result word changed");

endmodule

FILE: design/brb_ram.sv
`timescale 1ns / 1ps
// brb_ram: generic single-write, single-read ram with registered read data
// no dependencies

module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/brb_ctrl.sv
`timescale 1ns / 1ps
// brb_ctrl: pointers, transfer tracking, admission checks and peak fill
// depends on brb_pkg; drives the byte store ram in the top level

module brb_ctrl import brb_pkg::*; #(
  parameter int DEPTH = 256,
  localparam int PW  = $clog2(DEPTH),
  localparam int SZW = PW + 1,
  localparam int EW  = ((PW > 8) ? PW : 8) + 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             acc,
  input  req_t             req,
  output res_t             res,
  output logic             mem_we,
  output logic             mem_re,
  output logic [PW-1:0]    mem_addr,
  output logic [7:0]       mem_wdata
);

  localparam int RST_SIZE = (DEPTH < 256) ? DEPTH : 256;

  logic [PW-1:0]  rd_ptr, rd_ptr_next;
  logic [PW-1:0]  wr_ptr, wr_ptr_next;
  logic [PW-1:0]  wk_ptr, wk_ptr_next;
  logic [7:0]     remaining, remaining_next;
  logic           kind, kind_next;
  logic           rejected, rejected_next;
  logic [7:0]     peak, peak_next;
  logic [SZW-1:0] size;

  logic [SZW-1:0] size_cfg;
  logic [31:0]    cfg_ext;
  logic           idle, is_query;
  logic [PW-1:0]  fill_cur, fill_after;
  logic [EW-1:0]  sum, fill_ext;
  logic           over, under;
  logic [SZW-1:0] wk_inc;

  function automatic logic [PW-1:0] fill_of(input logic [PW-1:0] w, input logic [PW-1:0] r,
                                            input logic [SZW-1:0] sz);
    logic [SZW-1:0] t;
    if (w >= r) begin
      t = SZW'(w) - SZW'(r);
    end else begin
      t = SZW'(w) + sz - SZW'(r);
    end
    return t[PW-1:0];
  endfunction

  assign cfg_ext  = 32'(cfg_data);
  assign size_cfg = (cfg_ext < 32'(MIN_SIZE)) ? SZW'(MIN_SIZE) :
                    (cfg_ext > 32'(DEPTH))    ? SZW'(DEPTH) : SZW'(cfg_ext);

  assign idle     = (remaining == 8'd0);
  assign is_query = idle && (req.req_type != REQ_APPEND) && (req.req_type != REQ_POP);
  assign fill_cur = fill_of(wr_ptr, rd_ptr, size);
  assign sum      = EW'(fill_cur) + EW'(req.transfer_count);
  assign over     = (sum >= EW'(size));
  assign under    = (EW'(fill_cur) < EW'(req.transfer_count));

  always_comb begin
    rd_ptr_next    = rd_ptr;
    wr_ptr_next    = wr_ptr;
    wk_ptr_next    = wk_ptr;
    remaining_next = remaining;
    kind_next      = kind;
    rejected_next  = rejected;
    peak_next      = peak;
    wk_inc         = '0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_addr       = wk_ptr;
    mem_wdata      = req.data_in;
    res.status     = ST_OK;
    res.last       = 1'b0;
    res.has_space  = 1'b0;
    res.pop_data   = 1'b0;
    if (acc) begin
      if (is_query) begin
        res.has_space = !over;
        res.last      = 1'b1;
      end else begin
        if (idle) begin
          kind_next = (req.req_type == REQ_POP);
          if (!kind_next) begin
            rejected_next = over;
            if (!over) begin
              wk_ptr_next = wr_ptr;
              if (sum > EW'(peak)) begin
                peak_next = (sum > EW'(255)) ? 8'hFF : sum[7:0];
              end
            end
          end else begin
            rejected_next = under;
            if (!under) begin
              wk_ptr_next = rd_ptr;
            end
          end
          remaining_next = req.transfer_count;
        end
        if (remaining_next == 8'd0) begin
          // empty transfer ends on its opening word
          rejected_next = 1'b0;
          res.last      = 1'b1;
        end else begin
          if (rejected_next) begin
            res.status = kind_next ? ST_UNDERFLOW : ST_OVERFLOW;
          end else begin
            mem_addr     = wk_ptr_next;
            mem_we       = !kind_next;
            mem_re       = kind_next;
            res.pop_data = kind_next;
            wk_inc       = SZW'(wk_ptr_next) + SZW'(1);
            wk_ptr_next  = (wk_inc >= size) ? '0 : wk_inc[PW-1:0];
          end
          remaining_next = remaining_next - 8'd1;
          if (remaining_next == 8'd0) begin
            res.last = 1'b1;
            if (!rejected_next) begin
              if (kind_next) begin
                rd_ptr_next = wk_ptr_next;
              end else begin
                wr_ptr_next = wk_ptr_next;
              end
            end
            rejected_next = 1'b0;
          end
        end
      end
    end
    fill_after     = fill_of(wr_ptr_next, rd_ptr_next, size);
    fill_ext       = EW'(fill_after);
    res.fill_level = (fill_ext > EW'(255)) ? 8'hFF : fill_ext[7:0];
    res.peak_usage = peak_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      wk_ptr    <= '0;
      remaining <= '0;
      kind      <= 1'b0;
      rejected  <= 1'b0;
      peak      <= '0;
      size      <= SZW'(RST_SIZE);
    end else if (cfg_we) begin
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      wk_ptr    <= '0;
      remaining <= '0;
      kind      <= 1'b0;
      rejected  <= 1'b0;
      size      <= size_cfg;
    end else begin
      rd_ptr    <= rd_ptr_next;
      wr_ptr    <= wr_ptr_next;
      wk_ptr    <= wk_ptr_next;
      remaining <= remaining_next;
      kind      <= kind_next;
      rejected  <= rejected_next;
      peak      <= peak_next;
    end
  end

  a_mem_excl: assert property (@(posedge clk) disable iff (rst) !(mem_we && mem_re))
    else $error("ram written and read in the same cycle");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (SZW'(rd_ptr) < size) && (SZW'(wr_ptr) < size))
    else $error("committed pointer beyond buffer size");

  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> (remaining == 8'd0) && !rejected)
    else $error("size write left a transfer open");

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (acc && res.last) |=> (remaining == 8'd0) && !rejected)
    else $error("transfer still open after its last word");

endmodule
